>>> src/pcq_pkg.sv
`timescale 1ns / 1ps

package pcq_pkg;

  localparam int unsigned NUM_COLORS = 16;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned CHAN_W     = 8;
  // weighted distance peaks at 10 * 255^2 = 650250
  localparam int unsigned DIST_W     = 20;
  // luma sum 30r + 59g + 11b peaks at 25500
  localparam int unsigned SUM_W      = 15;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // mode register codes; the unused code behaves as eight-level gray
  localparam logic [1:0] MODE_COLOR = 2'd0;
  localparam logic [1:0] MODE_GRAY4 = 2'd1;
  localparam logic [1:0] MODE_GRAY8 = 2'd2;

  // floor(sum / 100) < t  holds exactly when  sum < 100 * t
  localparam int unsigned LUMA_SCALE = 100;
  localparam logic [SUM_W-1:0] LUMA_32  = SUM_W'(32 * LUMA_SCALE);
  localparam logic [SUM_W-1:0] LUMA_64  = SUM_W'(64 * LUMA_SCALE);
  localparam logic [SUM_W-1:0] LUMA_80  = SUM_W'(80 * LUMA_SCALE);
  localparam logic [SUM_W-1:0] LUMA_112 = SUM_W'(112 * LUMA_SCALE);
  localparam logic [SUM_W-1:0] LUMA_128 = SUM_W'(128 * LUMA_SCALE);
  localparam logic [SUM_W-1:0] LUMA_144 = SUM_W'(144 * LUMA_SCALE);
  localparam logic [SUM_W-1:0] LUMA_176 = SUM_W'(176 * LUMA_SCALE);
  localparam logic [SUM_W-1:0] LUMA_192 = SUM_W'(192 * LUMA_SCALE);
  localparam logic [SUM_W-1:0] LUMA_208 = SUM_W'(208 * LUMA_SCALE);
  localparam logic [SUM_W-1:0] LUMA_240 = SUM_W'(240 * LUMA_SCALE);

  typedef struct packed {
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
  } rgb_t;

  // what travels from one cell to the next
  typedef struct packed {
    logic              valid;
    rgb_t              pix;
    logic [1:0]        mode;
    logic [SUM_W-1:0]  luma_sum;
    logic [DIST_W-1:0] best_dist;
    logic [IDX_W-1:0]  best_idx;
  } chain_t;

  function automatic rgb_t pal_color(input logic [IDX_W-1:0] idx);
    rgb_t c;
    case (idx)
      4'd0:    c = '{r: 8'd0,   g: 8'd0,   b: 8'd0};
      4'd1:    c = '{r: 8'd0,   g: 8'd0,   b: 8'd128};
      4'd2:    c = '{r: 8'd0,   g: 8'd128, b: 8'd0};
      4'd3:    c = '{r: 8'd0,   g: 8'd128, b: 8'd128};
      4'd4:    c = '{r: 8'd128, g: 8'd0,   b: 8'd0};
      4'd5:    c = '{r: 8'd128, g: 8'd0,   b: 8'd128};
      4'd6:    c = '{r: 8'd128, g: 8'd64,  b: 8'd0};
      4'd7:    c = '{r: 8'd192, g: 8'd192, b: 8'd192};
      4'd8:    c = '{r: 8'd128, g: 8'd128, b: 8'd128};
      4'd9:    c = '{r: 8'd0,   g: 8'd0,   b: 8'd255};
      4'd10:   c = '{r: 8'd0,   g: 8'd255, b: 8'd0};
      4'd11:   c = '{r: 8'd0,   g: 8'd255, b: 8'd255};
      4'd12:   c = '{r: 8'd255, g: 8'd0,   b: 8'd0};
      4'd13:   c = '{r: 8'd255, g: 8'd0,   b: 8'd255};
      4'd14:   c = '{r: 8'd255, g: 8'd255, b: 8'd0};
      default: c = '{r: 8'd255, g: 8'd255, b: 8'd255};
    endcase
    return c;
  endfunction

endpackage

>>> src/pcq_front.sv
`timescale 1ns / 1ps

module pcq_front
  import pcq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [CHAN_W-1:0] red,
  input  logic [CHAN_W-1:0] green,
  input  logic [CHAN_W-1:0] blue,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_data,
  output chain_t            head
);

  logic [1:0]       quant_mode;
  logic [SUM_W-1:0] luma_sum_next;

  // constant weights, adders only after synthesis
  assign luma_sum_next = SUM_W'(red)   * SUM_W'(30)
                       + SUM_W'(green) * SUM_W'(59)
                       + SUM_W'(blue)  * SUM_W'(11);

  always_ff @(posedge clk) begin
    if (rst) begin
      quant_mode <= MODE_COLOR;
    end else if (cfg_we) begin
      quant_mode <= cfg_data;
    end
  end

  // only the valid flag is reset, the payload just follows the inputs
  always_ff @(posedge clk) begin
    if (rst) begin
      head.valid <= 1'b0;
    end else begin
      head.valid <= accept;
    end
    head.pix       <= '{r: red, g: green, b: blue};
    head.mode      <= quant_mode;
    head.luma_sum  <= luma_sum_next;
    head.best_dist <= DIST_MAX;
    head.best_idx  <= '0;
  end

endmodule

>>> src/pcq_cell.sv
`timescale 1ns / 1ps

module pcq_cell
  import pcq_pkg::*;
#(
  parameter logic [IDX_W-1:0] CELL_IDX = 4'd0
)
(
  input  logic   clk,
  input  logic   rst,
  input  chain_t up,
  output chain_t down
);

  localparam rgb_t ENTRY = pal_color(CELL_IDX);

  logic [CHAN_W-1:0]   dr;
  logic [CHAN_W-1:0]   dg;
  logic [CHAN_W-1:0]   db;
  logic [2*CHAN_W-1:0] sq_r;
  logic [2*CHAN_W-1:0] sq_g;
  logic [2*CHAN_W-1:0] sq_b;
  logic [DIST_W-1:0]   cand_dist;
  logic                closer;

  assign dr = (up.pix.r > ENTRY.r) ? up.pix.r - ENTRY.r : ENTRY.r - up.pix.r;
  assign dg = (up.pix.g > ENTRY.g) ? up.pix.g - ENTRY.g : ENTRY.g - up.pix.g;
  assign db = (up.pix.b > ENTRY.b) ? up.pix.b - ENTRY.b : ENTRY.b - up.pix.b;

  assign sq_r = dr * dr;
  assign sq_g = dg * dg;
  assign sq_b = db * db;

  // 3*r + 6*g + b as shifts and adds
  assign cand_dist = (DIST_W'(sq_r) << 1) + DIST_W'(sq_r)
                   + (DIST_W'(sq_g) << 2) + (DIST_W'(sq_g) << 1)
                   + DIST_W'(sq_b);

  // strict compare keeps the lower index on a tie
  assign closer = cand_dist < up.best_dist;

  always_ff @(posedge clk) begin
    if (rst) begin
      down.valid <= 1'b0;
    end else begin
      down.valid <= up.valid;
    end
    down.pix       <= up.pix;
    down.mode      <= up.mode;
    down.luma_sum  <= up.luma_sum;
    down.best_dist <= closer ? cand_dist : up.best_dist;
    down.best_idx  <= closer ? CELL_IDX : up.best_idx;
  end

endmodule

>>> src/pcq_out.sv
`timescale 1ns / 1ps

module pcq_out
  import pcq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  chain_t           tail,
  output logic             result_valid,
  output logic [IDX_W-1:0] palette_index
);

  logic [IDX_W-1:0] gray4_idx;
  logic [IDX_W-1:0] gray8_idx;
  logic [IDX_W-1:0] index_next;

  always_comb begin
    if (tail.luma_sum < LUMA_64) begin
      gray4_idx = 4'd0;
    end else if (tail.luma_sum < LUMA_128) begin
      gray4_idx = 4'd8;
    end else if (tail.luma_sum < LUMA_192) begin
      gray4_idx = 4'd7;
    end else begin
      gray4_idx = 4'd15;
    end
  end

  always_comb begin
    if (tail.luma_sum < LUMA_32) begin
      gray8_idx = 4'd0;
    end else if (tail.luma_sum < LUMA_80) begin
      gray8_idx = 4'd1;
    end else if (tail.luma_sum < LUMA_112) begin
      gray8_idx = 4'd2;
    end else if (tail.luma_sum < LUMA_144) begin
      gray8_idx = 4'd8;
    end else if (tail.luma_sum < LUMA_176) begin
      gray8_idx = 4'd3;
    end else if (tail.luma_sum < LUMA_208) begin
      gray8_idx = 4'd7;
    end else if (tail.luma_sum < LUMA_240) begin
      gray8_idx = 4'd4;
    end else begin
      gray8_idx = 4'd15;
    end
  end

  always_comb begin
    case (tail.mode)
      MODE_COLOR: index_next = tail.best_idx;
      MODE_GRAY4: index_next = gray4_idx;
      MODE_GRAY8: index_next = gray8_idx;
      default:    index_next = gray8_idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= tail.valid;
    end
  end

  always_ff @(posedge clk) begin
    palette_index <= index_next;
  end

endmodule

>>> src/palette_color_quantizer_unit.sv
`timescale 1ns / 1ps
// palette color quantizer: maps one rgb888 pixel to a 4-bit palette index
//
// pixel channel: drive red/green/blue and raise start; the request is taken
// at any rising edge where start is high and busy is low. busy is high only
// while rst is asserted, so one pixel can be taken in every clock cycle.
// result channel: result_valid is high for exactly one cycle with
// palette_index; the receiver cannot stall and must take it then.
// pipeline: a taken request passes the front register, the 16-cell distance
// chain and the output register before result_valid; throughput is one pixel
// per cycle outside reset, each cell testing one palette entry per cycle.
// config channel: cfg_valid/cfg_ready write quant_mode (cfg_data); change it
// only while no pixel is in flight. each pixel carries the mode it saw.
// reset: synchronous rst clears all valid flags and sets quant_mode to
// nearest-color mode; pixels in flight are dropped.

module palette_color_quantizer_unit
  import pcq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [CHAN_W-1:0] red,
  input  logic [CHAN_W-1:0] green,
  input  logic [CHAN_W-1:0] blue,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_data,
  output logic              result_valid,
  output logic [IDX_W-1:0]  palette_index
);

  // front register, one stage per palette entry, output register
  localparam int unsigned LATENCY = NUM_COLORS + 2;

  chain_t chain [0:NUM_COLORS];
  logic   accept;
  logic   cfg_we;

  // no back-pressure anywhere, so the only busy time is reset
  assign busy      = rst;
  assign cfg_ready = ~rst;
  assign accept    = start & ~busy;
  assign cfg_we    = cfg_valid & cfg_ready;

  // capture pixel, mode and luma sum
  pcq_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .red      (red),
    .green    (green),
    .blue     (blue),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .head     (chain[0])
  );

  // each cell compares against its own palette entry and forwards the best
  for (genvar i = 0; i < NUM_COLORS; i++) begin : g_cell
    pcq_cell #(
      .CELL_IDX (IDX_W'(i))
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .up   (chain[i]),
      .down (chain[i+1])
    );
  end

  // mode select and gray thresholds
  pcq_out u_out (
    .clk           (clk),
    .rst           (rst),
    .tail          (chain[NUM_COLORS]),
    .result_valid  (result_valid),
    .palette_index (palette_index)
  );

`ifndef ASSERT_OFF
  // every request comes out after the fixed latency
  a_req_to_result: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY result_valid)
    else $error("request did not produce a result");

  // no result without a matching request
  a_result_from_req: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(accept, LATENCY))
    else $error("result without a request");

  // the first cell always replaces the initial distance
  a_first_cell_wins: assert property (@(posedge clk) disable iff (rst)
    chain[1].valid |-> (chain[1].best_dist != DIST_MAX))
    else $error("first cell kept the initial distance");
`endif

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import pcq_pkg::*;

  // the fourth mode code has no name in the package; it acts as eight-level gray
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // pipeline depth from request to result strobe
  localparam int LATENCY     = 18;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_PHASE  = 250;
  localparam int NUM_PHASES  = 6;

  // palette as {r, g, b} per entry, entry 0 in the low bits
  localparam logic [16*24-1:0] PALETTE = {
    24'hFFFFFF, 24'hFFFF00, 24'hFF00FF, 24'hFF0000,
    24'h00FFFF, 24'h00FF00, 24'h0000FF, 24'h808080,
    24'hC0C0C0, 24'h804000, 24'h800080, 24'h800000,
    24'h008080, 24'h008000, 24'h000080, 24'h000000
  };

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [1:0]        cfg_data;
  logic              result_valid;
  logic [IDX_W-1:0]  palette_index;

  int cycle_count;

  // tracks the expected palette index of every pixel in flight
  class index_tracker;
    logic [IDX_W-1:0] expected_idx[$];
    logic [1:0]       mode;
    int               errors;

    function new();
      mode   = MODE_COLOR;
      errors = 0;
    endfunction

    function automatic int unsigned sq_dist(int unsigned a, int unsigned b);
      int unsigned d;
      d = (a > b) ? a - b : b - a;
      return d * d;
    endfunction

    function automatic logic [IDX_W-1:0] nearest_entry(logic [7:0] r, logic [7:0] g,
                                                        logic [7:0] b);
      int unsigned      best_dist;
      int unsigned      cand_dist;
      logic [IDX_W-1:0] best;
      logic [23:0]      c;
      best_dist = 32'hFFFF_FFFF;
      best      = '0;
      for (int i = 0; i < 16; i++) begin
        c         = PALETTE[i*24 +: 24];
        cand_dist = 3 * sq_dist(r, c[23:16]) + 6 * sq_dist(g, c[15:8])
                  + sq_dist(b, c[7:0]);
        // strict compare keeps the lowest index on a tie
        if (cand_dist < best_dist) begin
          best_dist = cand_dist;
          best      = IDX_W'(i);
        end
      end
      return best;
    endfunction

    function automatic logic [IDX_W-1:0] gray4_entry(int unsigned y);
      if (y < 64)  return 4'd0;
      if (y < 128) return 4'd8;
      if (y < 192) return 4'd7;
      return 4'd15;
    endfunction

    function automatic logic [IDX_W-1:0] gray8_entry(int unsigned y);
      if (y < 32)  return 4'd0;
      if (y < 80)  return 4'd1;
      if (y < 112) return 4'd2;
      if (y < 144) return 4'd8;
      if (y < 176) return 4'd3;
      if (y < 208) return 4'd7;
      if (y < 240) return 4'd4;
      return 4'd15;
    endfunction

    function automatic logic [IDX_W-1:0] predict_index(logic [7:0] r, logic [7:0] g,
                                                        logic [7:0] b);
      int unsigned y;
      y = (30 * int'(r) + 59 * int'(g) + 11 * int'(b)) / 100;
      case (mode)
        MODE_COLOR: return nearest_entry(r, g, b);
        MODE_GRAY4: return gray4_entry(y);
        default:    return gray8_entry(y);
      endcase
    endfunction

    task report_mismatch(string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      errors++;
    endtask

    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      expected_idx.push_back(predict_index(r, g, b));
    endfunction

    task check_index(logic [IDX_W-1:0] got);
      logic [IDX_W-1:0] want;
      if (expected_idx.size() == 0) begin
        report_mismatch($sformatf("result %0d with no pixel pending", got));
      end else begin
        want = expected_idx.pop_front();
        if (got !== want)
          report_mismatch($sformatf("palette_index %0d, expected %0d", got, want));
      end
    endtask

    function int pending();
      return expected_idx.size();
    endfunction
  endclass

  index_tracker tracker;

  palette_color_quantizer_unit dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .palette_index(palette_index)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog against a hung handshake or a lost result
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("testbench NOT OK");
      $finish;
    end
  end

  // the result strobe lasts one cycle and cannot be held off, so take it every edge
  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1)
      tracker.check_index(palette_index);
  end

  // one pixel request; start stays high on return so back-to-back requests
  // keep it high without a glitch, the next action decides whether to drop it
  task send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    @(negedge clk);
    start = 1'b1;
    red   = r;
    green = g;
    blue  = b;
    do @(posedge clk); while (busy !== 1'b0);
    tracker.note_pixel(r, g, b);
  endtask

  task send_gray(logic [7:0] v);
    send_pixel(v, v, v);
  endtask

  // sender goes quiet, with start held low
  task idle_burst(int n);
    @(negedge clk);
    start = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // stop sending and wait for every pending result
  task drain();
    @(negedge clk);
    start = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // mode change only with nothing in flight
  task set_mode(logic [1:0] m);
    drain();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = m;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    tracker.mode = m;
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_data  = 2'($urandom_range(0, 3));
  endtask

  // channel value biased toward palette levels, midpoints and extremes
  function automatic logic [7:0] pick_chan();
    int base;
    int v;
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(0, 255));
      1: begin
        case ($urandom_range(0, 4))
          0:       base = 0;
          1:       base = 64;
          2:       base = 128;
          3:       base = 192;
          default: base = 255;
        endcase
        v = base + int'($urandom_range(0, 4)) - 2;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return 8'(v);
      end
      2: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      default: begin
        // halfway between palette levels, where ties and near ties live
        case ($urandom_range(0, 4))
          0:       base = 32;
          1:       base = 64;
          2:       base = 96;
          3:       base = 160;
          default: base = 224;
        endcase
        v = base + int'($urandom_range(0, 2)) - 1;
        return 8'(v);
      end
    endcase
  endfunction

  initial begin
    logic [1:0] phase_mode;
    logic [7:0] y;
    bit         quiet;
    tracker     = new();
    cycle_count = 0;
    rst         = 1'b1;
    start       = 1'b0;
    red         = '0;
    green       = '0;
    blue        = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // directed: color mode from reset, corners and tie cases
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd0, 8'd0, 8'd64);     // black vs navy tie
    send_pixel(8'd64, 8'd0, 8'd0);     // black vs maroon tie
    send_pixel(8'd0, 8'd64, 8'd0);     // black vs green tie
    send_pixel(8'd192, 8'd192, 8'd192);
    send_pixel(8'd128, 8'd64, 8'd0);

    // four-level gray around each threshold
    set_mode(MODE_GRAY4);
    send_gray(8'd63);
    send_gray(8'd64);
    send_gray(8'd127);
    send_gray(8'd128);
    send_gray(8'd191);
    send_gray(8'd192);

    // eight-level gray at each threshold
    set_mode(MODE_GRAY8);
    send_gray(8'd31);
    send_gray(8'd32);
    send_gray(8'd80);
    send_gray(8'd112);
    send_gray(8'd144);
    send_gray(8'd176);
    send_gray(8'd208);
    send_gray(8'd240);
    send_gray(8'd255);

    // unused mode code falls back to eight-level gray
    set_mode(MODE_SPARE);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd100, 8'd100, 8'd100);
    send_pixel(8'd255, 8'd255, 8'd255);

    // random phases, cycling every mode; the last phase streams without gaps
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0:       phase_mode = MODE_COLOR;
        1:       phase_mode = MODE_GRAY4;
        2:       phase_mode = MODE_SPARE;
        default: phase_mode = MODE_GRAY8;
      endcase
      set_mode(phase_mode);
      quiet = (p == NUM_PHASES - 1);
      for (int i = 0; i < RAND_PHASE; i++) begin
        if (p == 1 && i == RAND_PHASE / 2)
          drain();
        if (!quiet && $urandom_range(0, 7) == 0)
          idle_burst($urandom_range(1, 15));
        if (phase_mode != MODE_COLOR && $urandom_range(0, 3) == 0) begin
          // gray pixels land luma on a chosen value, near thresholds
          y = pick_chan();
          send_gray(y);
        end else begin
          send_pixel(pick_chan(), pick_chan(), pick_chan());
        end
      end
    end

    drain();
    // watch for stray strobes after the last expected result
    repeat (LATENCY + 5) @(posedge clk);
    if (tracker.pending() != 0)
      tracker.report_mismatch($sformatf("%0d results never arrived", tracker.pending()));
    if (tracker.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
